>>> design/jet_pkg.sv
package jet_pkg;

	// Q4.28 operand and iteration counter widths
	localparam int ZW   = 32;
	localparam int CNTW = 16;

	// Configuration port
	localparam int IDXW  = 3;
	localparam int DATAW = 32;

	localparam logic [IDXW-1:0] REG_ITER_LIMIT = 3'd0;
	localparam logic [IDXW-1:0] REG_REAL_MIN   = 3'd1;
	localparam logic [IDXW-1:0] REG_REAL_MAX   = 3'd2;
	localparam logic [IDXW-1:0] REG_IMAG_MIN   = 3'd3;
	localparam logic [IDXW-1:0] REG_IMAG_MAX   = 3'd4;
	localparam logic [IDXW-1:0] REG_CONST_REAL = 3'd5;
	localparam logic [IDXW-1:0] REG_CONST_IMAG = 3'd6;

	// Escape bound: 4.0 in Q8.56
	localparam logic [63:0] MAG_LIMIT = 64'h0400_0000_0000_0000;

	typedef struct packed {
		logic [CNTW-1:0] iteration_limit;
		logic [ZW-1:0]   window_real_min;
		logic [ZW-1:0]   window_real_max;
		logic [ZW-1:0]   window_imag_min;
		logic [ZW-1:0]   window_imag_max;
		logic [ZW-1:0]   const_real;
		logic [ZW-1:0]   const_imag;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic map;
		logic start;
		logic mul;
		logic upd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic at_limit;
		logic escaped;
	} sts_t;

endpackage

>>> design/jet_cfg.sv
module jet_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [jet_pkg::IDXW-1:0]   cfg_index,
	input  logic [jet_pkg::DATAW-1:0]  cfg_data,
	output jet_pkg::cfg_t              cfg
);

	jet_pkg::cfg_t cfg_q;

	// Write one register per transaction; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iteration_limit <= 16'd1000;
			cfg_q.window_real_min <= 32'hE000_0000;
			cfg_q.window_real_max <= 32'h1000_0000;
			cfg_q.window_imag_min <= 32'hF000_0000;
			cfg_q.window_imag_max <= 32'h1000_0000;
			cfg_q.const_real      <= 32'h0000_0000;
			cfg_q.const_imag      <= 32'h0000_0000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				jet_pkg::REG_ITER_LIMIT: begin
					cfg_q.iteration_limit <= cfg_data[jet_pkg::CNTW-1:0];
				end
				jet_pkg::REG_REAL_MIN:   cfg_q.window_real_min <= cfg_data;
				jet_pkg::REG_REAL_MAX:   cfg_q.window_real_max <= cfg_data;
				jet_pkg::REG_IMAG_MIN:   cfg_q.window_imag_min <= cfg_data;
				jet_pkg::REG_IMAG_MAX:   cfg_q.window_imag_max <= cfg_data;
				jet_pkg::REG_CONST_REAL: cfg_q.const_real      <= cfg_data;
				jet_pkg::REG_CONST_IMAG: cfg_q.const_imag      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/jet_ctrl.sv
module jet_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  jet_pkg::sts_t sts,
	output jet_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_MAP   = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_UPD   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// Sequence one pixel: form the steps, map, then square-and-add until exit
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = S_MAP;
			end
			S_MAP: begin
				cmd.map = 1'b1;
				state_d = S_START;
			end
			S_START: begin
				cmd.start = 1'b1;
				state_d   = S_MUL;
			end
			S_MUL: begin
				if (sts.at_limit) begin
					state_d = S_DONE;
				end else begin
					cmd.mul = 1'b1;
					state_d = S_UPD;
				end
			end
			S_UPD: begin
				if (sts.escaped) begin
					state_d = S_DONE;
				end else begin
					cmd.upd = 1'b1;
					state_d = S_MUL;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Advance state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

>>> design/jet_dp.sv
module jet_dp #(
	parameter int IMAGE_WIDTH  = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic                      clk,
	input  jet_pkg::cmd_t             cmd,
	input  jet_pkg::cfg_t             cfg,
	input  logic [9:0]                pixel_col,
	input  logic [9:0]                pixel_row,
	output jet_pkg::sts_t             sts,
	output logic [jet_pkg::CNTW-1:0]  iteration_count,
	output logic                      reached_limit
);

	// Reciprocals of the step divisors: ceil(2^SH / D), which lies in [2^32, 2^33),
	// so only the low 32 bits need a multiplier
	localparam int DIV_R = IMAGE_WIDTH - 1;
	localparam int DIV_I = IMAGE_HEIGHT - 1;
	localparam int SH_R  = 32 + $clog2(DIV_R);
	localparam int SH_I  = 32 + $clog2(DIV_I);
	localparam logic [63:0] RCP_R = ((64'd1 << SH_R) + 64'(DIV_R) - 64'd1) / 64'(DIV_R);
	localparam logic [63:0] RCP_I = ((64'd1 << SH_I) + 64'(DIV_I) - 64'd1) / 64'(DIV_I);
	localparam logic [31:0] RCP_R_LO = RCP_R[31:0];
	localparam logic [31:0] RCP_I_LO = RCP_I[31:0];

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic [9:0]                col_q;
	logic [9:0]                row_q;
	logic                      neg_r_q;
	logic                      neg_i_q;
	logic [31:0]               num_r_q;
	logic [31:0]               num_i_q;
	logic signed [43:0]        prod_r_q;
	logic signed [43:0]        prod_i_q;
	logic signed [31:0]        zr_q;
	logic signed [31:0]        zi_q;
	logic [jet_pkg::CNTW-1:0]  count_q;
	logic signed [63:0]        rr_q;
	logic signed [63:0]        ii_q;
	logic signed [63:0]        ri_q;
	logic [jet_pkg::CNTW-1:0]  count_out_q;
	logic                      limit_out_q;

	logic signed [32:0] diff_r;
	logic signed [32:0] diff_i;
	logic [32:0]        abs_r;
	logic [32:0]        abs_i;
	logic [63:0]        rcp_prod_r;
	logic [63:0]        rcp_prod_i;
	logic [64:0]        rcp_sum_r;
	logic [64:0]        rcp_sum_i;
	logic [31:0]        quo_r;
	logic [31:0]        quo_i;
	logic signed [32:0] step_r;
	logic signed [32:0] step_i;
	logic signed [44:0] z0_r;
	logic signed [44:0] z0_i;
	logic [63:0]        mag;
	logic signed [63:0] sq_diff;
	logic signed [63:0] nr_pre;
	logic signed [63:0] ni_pre;

	// Window spans and their magnitudes
	assign diff_r = 33'($signed(cfg.window_real_max)) - 33'($signed(cfg.window_real_min));
	assign diff_i = 33'($signed(cfg.window_imag_max)) - 33'($signed(cfg.window_imag_min));
	assign abs_r  = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);
	assign abs_i  = diff_i[32] ? 33'(-diff_i) : 33'(diff_i);

	// Divide the span magnitudes by reciprocal multiplication
	assign rcp_prod_r = {32'd0, num_r_q} * {32'd0, RCP_R_LO};
	assign rcp_prod_i = {32'd0, num_i_q} * {32'd0, RCP_I_LO};
	assign rcp_sum_r  = {1'b0, num_r_q, 32'd0} + {1'b0, rcp_prod_r};
	assign rcp_sum_i  = {1'b0, num_i_q, 32'd0} + {1'b0, rcp_prod_i};
	assign quo_r      = 32'(rcp_sum_r >> SH_R);
	assign quo_i      = 32'(rcp_sum_i >> SH_I);

	// Quotient with the span's sign, truncated toward zero
	assign step_r = neg_r_q ? -$signed({1'b0, num_r_q}) : $signed({1'b0, num_r_q});
	assign step_i = neg_i_q ? -$signed({1'b0, num_i_q}) : $signed({1'b0, num_i_q});

	// Start point: real from the left edge, imaginary down from the top
	assign z0_r = 45'($signed(cfg.window_real_min)) + 45'(prod_r_q);
	assign z0_i = 45'($signed(cfg.window_imag_max)) - 45'(prod_i_q);

	// Magnitude test and next z from the registered products
	assign mag     = $unsigned(rr_q) + $unsigned(ii_q);
	assign sq_diff = rr_q - ii_q;
	assign nr_pre  = (sq_diff >>> 28) + 64'($signed(cfg.const_real));
	assign ni_pre  = (ri_q >>> 27) + 64'($signed(cfg.const_imag));

	always_ff @(posedge clk) begin
		// Capture the pixel and the span magnitudes, then replace them by the quotients
		if (cmd.load) begin
			col_q   <= pixel_col;
			row_q   <= pixel_row;
			neg_r_q <= diff_r[32];
			neg_i_q <= diff_i[32];
			num_r_q <= abs_r[31:0];
			num_i_q <= abs_i[31:0];
		end else if (cmd.div_step) begin
			num_r_q <= quo_r;
			num_i_q <= quo_i;
		end

		// Scale the steps by the pixel position
		if (cmd.map) begin
			prod_r_q <= $signed({1'b0, col_q}) * step_r;
			prod_i_q <= $signed({1'b0, row_q}) * step_i;
		end

		// Load z, or advance it by one square-and-add
		if (cmd.start) begin
			zr_q    <= sat32(64'(z0_r));
			zi_q    <= sat32(64'(z0_i));
			count_q <= '0;
		end else if (cmd.upd) begin
			zr_q    <= sat32(nr_pre);
			zi_q    <= sat32(ni_pre);
			count_q <= count_q + 1'b1;
		end

		// Form the exact Q8.56 products
		if (cmd.mul) begin
			rr_q <= zr_q * zr_q;
			ii_q <= zi_q * zi_q;
			ri_q <= zr_q * zi_q;
		end

		// Hold the finished result for the output transaction
		if (cmd.emit) begin
			count_out_q <= count_q;
			limit_out_q <= sts.at_limit;
		end
	end

	assign sts.at_limit   = (count_q == cfg.iteration_limit);
	assign sts.escaped    = (mag > jet_pkg::MAG_LIMIT);
	assign iteration_count = count_out_q;
	assign reached_limit   = limit_out_q;

endmodule

>>> design/julia_escape_time.sv
// Julia set escape-time engine, one pixel per transaction. The pixel is
// mapped onto the configured complex window (steps are the window spans
// divided by IMAGE_WIDTH-1 and IMAGE_HEIGHT-1), then z = z^2 + c runs in
// signed Q4.28 with exact 64-bit products until |z|^2 exceeds 4 or the count
// reaches iteration_limit. After acceptance, a divide state forms both
// steps by reciprocal multiplication, a map and a start state map the pixel
// onto its start point, each iteration passes through the shared complex
// squaring path (a multiply state, then a magnitude-test and update state),
// one last check finds the exit, and a done state loads the output
// register. The engine is ready again the cycle after that. One pixel is in
// flight at a time; the next is accepted while the previous result still
// waits in the output register, and the engine only stalls if that result
// is still waiting when the next one is done. Configuration registers are
// written with cfg_we, cfg_index and cfg_data; the user must write them
// only while the block is idle, as the block itself does not enforce it;
// writes to unknown indexes are dropped.
module julia_escape_time #(
	parameter int IMAGE_WIDTH  = 1024,
	parameter int IMAGE_HEIGHT = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [jet_pkg::IDXW-1:0]   cfg_index,
	input  logic [jet_pkg::DATAW-1:0]  cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [9:0]                 pixel_col,
	input  logic [9:0]                 pixel_row,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [jet_pkg::CNTW-1:0]   iteration_count,
	output logic                       reached_limit
);

	jet_pkg::cfg_t cfg;
	jet_pkg::cmd_t cmd;
	jet_pkg::sts_t sts;

	jet_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	jet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	jet_dp #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT)
	) u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.cfg             (cfg),
		.pixel_col       (pixel_col),
		.pixel_row       (pixel_row),
		.sts             (sts),
		.iteration_count (iteration_count),
		.reached_limit   (reached_limit)
	);

`ifndef SYNTHESIS
	// A flagged result carries exactly the limit
	a_limit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reached_limit |-> iteration_count == cfg.iteration_limit)
		else $error("limit flag set with count not at the limit");

	// An escaped pixel stops below the limit
	a_escape_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reached_limit |-> iteration_count < cfg.iteration_limit)
		else $error("escaped pixel reports count at or above the limit");

	// An accepted pixel occupies the engine
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("engine ready again right after accepting a pixel");
`endif

endmodule
